[sv/ffra_pkg.sv]
// Shared constants, codes and control types of the first-fit region allocator.
package ffra_pkg;

   localparam int MAX_REGION_ENTRIES = 128;
   localparam int MEMORY_WORDS       = 65536;

   localparam int FIELD_W  = 16;
   localparam int ADDR_W   = $clog2(MAX_REGION_ENTRIES);
   localparam int CNT_W    = $clog2(MAX_REGION_ENTRIES + 1);
   localparam int END_W    = FIELD_W + 1;
   localparam int SUM_W    = FIELD_W + 2;
   localparam int INUSE_W  = 8;
   localparam int ENTRY_W  = 2 * FIELD_W;
   localparam int REQ_DATA_W = 2 * FIELD_W;
   localparam int RSP_DATA_W = FIELD_W + INUSE_W;

   localparam logic [CNT_W-1:0] CNT_ZERO = '0;
   localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
   localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_REGION_ENTRIES);

   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_FREE  = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_FULL     = 2'd1,
      STATUS_NOMEM    = 2'd2,
      STATUS_NOTFOUND = 2'd3
   } status_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       load;
      logic       scan_start;
      logic       scan_run;
      logic       shift_start;
      logic       shift_run;
      logic       commit;
      logic       push;
      status_type code;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_free;
      logic count_full;
      logic scan_done;
      logic found;
      logic nomem;
      logic shift_done;
      logic out_free;
   } dp_sts_type;

endpackage

[sv/ffra_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module ffra_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

[sv/ffra_ctrl.sv]
// Controller state machine that sequences scan, shift, commit and response.
module ffra_ctrl import ffra_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  dp_sts_type   sts,
   output ctrl_cmd_type cmd
);

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_DECIDE = 7'b0000010,
      ST_SCAN   = 7'b0000100,
      ST_CHECK  = 7'b0001000,
      ST_SHIFT  = 7'b0010000,
      ST_COMMIT = 7'b0100000,
      ST_FINISH = 7'b1000000
   } state_type;

   state_type  state_ff, state_in;
   status_type code_ff, code_in;

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      code_in  = code_ff;
      cmd      = '0;
      cmd.code = code_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (!sts.is_free && sts.count_full) begin
               code_in  = STATUS_FULL;
               state_in = ST_FINISH;
            end else begin
               cmd.scan_start = 1'b1;
               state_in       = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan_run = 1'b1;
            if (sts.scan_done) begin
               if (!sts.is_free) begin
                  state_in = ST_CHECK;
               end else if (sts.found) begin
                  cmd.shift_start = 1'b1;
                  state_in        = ST_SHIFT;
               end else begin
                  code_in  = STATUS_NOTFOUND;
                  state_in = ST_FINISH;
               end
            end
         end
         ST_CHECK: begin
            if (sts.nomem) begin
               code_in  = STATUS_NOMEM;
               state_in = ST_FINISH;
            end else begin
               cmd.shift_start = 1'b1;
               state_in        = ST_SHIFT;
            end
         end
         ST_SHIFT: begin
            cmd.shift_run = 1'b1;
            if (sts.shift_done) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            cmd.commit = 1'b1;
            code_in    = STATUS_OK;
            state_in   = ST_FINISH;
         end
         ST_FINISH: begin
            if (sts.out_free) begin
               cmd.push = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         code_ff  <= STATUS_OK;
      end else begin
         state_ff <= state_in;
         code_ff  <= code_in;
      end
   end

endmodule

[sv/ffra_dp.sv]
// Datapath: region table, scan and shift pointers, gap search and result register.
module ffra_dp import ffra_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic [1:0]            rsp_tuser,
   input  ctrl_cmd_type          cmd,
   output dp_sts_type            sts
);

   logic               req_free_ff, req_free_in;
   logic [FIELD_W-1:0] size_ff, size_in;
   logic [FIELD_W-1:0] off_ff, off_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic               issue_ff, issue_in;
   logic               arr_valid_ff, arr_valid_in;
   logic [CNT_W-1:0]   arr_idx_ff, arr_idx_in;
   logic [END_W-1:0]   prev_end_ff, prev_end_in;
   logic [END_W-1:0]   base_ff, base_in;
   logic [CNT_W-1:0]   slot_ff, slot_in;
   logic               done_ff, done_in;
   logic               found_ff, found_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [1:0]         rsp_user_ff, rsp_user_in;

   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr;
   logic [ENTRY_W-1:0] wr_data;
   logic [ENTRY_W-1:0] rd_data;

   logic [FIELD_W-1:0] rd_start;
   logic [FIELD_W-1:0] rd_size;
   logic [END_W-1:0]   rd_end;
   logic [CNT_W-1:0]   count_last;
   logic [CNT_W-1:0]   shift_dst;
   logic               arr_last;
   logic               gap_fit;
   logic [FIELD_W-1:0] rsp_offset;

   ffra_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_REGION_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_ptr_ff[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   assign rd_start   = rd_data[FIELD_W-1:0];
   assign rd_size    = rd_data[ENTRY_W-1:FIELD_W];
   assign rd_end     = END_W'(rd_start) + END_W'(rd_size);
   assign count_last = count_ff - CNT_ONE;
   assign arr_last   = (arr_idx_ff == count_last);
   // Moved entry lands one slot down for a free, one slot up for an allocate.
   assign shift_dst  = req_free_ff ? (arr_idx_ff - CNT_ONE) : (arr_idx_ff + CNT_ONE);
   // Gap after the previous region is larger than the request.
   assign gap_fit    = (arr_idx_ff != CNT_ZERO) &&
                       (SUM_W'(rd_start) > (SUM_W'(prev_end_ff) + SUM_W'(size_ff)));

   assign sts.is_free    = req_free_ff;
   assign sts.count_full = (count_ff >= CNT_MAX);
   assign sts.scan_done  = done_ff;
   assign sts.found      = found_ff;
   assign sts.nomem      = (32'(base_ff) + 32'(size_ff)) >= 32'(MEMORY_WORDS);
   assign sts.shift_done = !issue_ff && !arr_valid_ff;
   assign sts.out_free   = !rsp_valid_ff || rsp_tready;

   assign rsp_offset = req_free_ff ? off_ff :
                       ((cmd.code == STATUS_OK) ? base_ff[FIELD_W-1:0] : '0);

   always_comb begin
      req_free_in  = req_free_ff;
      size_in      = size_ff;
      off_in       = off_ff;
      count_in     = count_ff;
      rd_ptr_in    = rd_ptr_ff;
      issue_in     = issue_ff;
      arr_valid_in = 1'b0;
      arr_idx_in   = arr_idx_ff;
      prev_end_in  = prev_end_ff;
      base_in      = base_ff;
      slot_in      = slot_ff;
      done_in      = done_ff;
      found_in     = found_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      wr_en        = 1'b0;
      wr_addr      = slot_ff[ADDR_W-1:0];
      wr_data      = {size_ff, base_ff[FIELD_W-1:0]};

      if (cmd.load) begin
         req_free_in = req_tuser;
         size_in     = req_tdata[FIELD_W-1:0];
         off_in      = req_tdata[REQ_DATA_W-1:FIELD_W];
      end

      if (cmd.scan_start) begin
         rd_ptr_in = CNT_ZERO;
         found_in  = 1'b0;
         slot_in   = CNT_ZERO;
         base_in   = '0;
         // An empty table ends the scan at once.
         issue_in  = (count_ff != CNT_ZERO);
         done_in   = (count_ff == CNT_ZERO);
      end

      if (cmd.scan_run) begin
         if (issue_ff) begin
            arr_valid_in = 1'b1;
            arr_idx_in   = rd_ptr_ff;
            rd_ptr_in    = rd_ptr_ff + CNT_ONE;
            issue_in     = (rd_ptr_ff != count_last);
         end
         if (arr_valid_ff && !done_ff) begin
            if (req_free_ff) begin
               if (rd_start == off_ff) begin
                  found_in = 1'b1;
                  slot_in  = arr_idx_ff;
                  done_in  = 1'b1;
                  issue_in = 1'b0;
               end else if (arr_last) begin
                  done_in  = 1'b1;
                  issue_in = 1'b0;
               end
            end else if (gap_fit) begin
               slot_in  = arr_idx_ff;
               base_in  = prev_end_ff;
               done_in  = 1'b1;
               issue_in = 1'b0;
            end else begin
               prev_end_in = rd_end;
               if (arr_last) begin
                  // No gap fits: append after the last region.
                  slot_in  = count_ff;
                  base_in  = rd_end;
                  done_in  = 1'b1;
                  issue_in = 1'b0;
               end
            end
         end
      end

      if (cmd.shift_start) begin
         if (req_free_ff) begin
            rd_ptr_in = slot_ff + CNT_ONE;
            issue_in  = ((slot_ff + CNT_ONE) != count_ff);
         end else begin
            rd_ptr_in = count_last;
            issue_in  = (slot_ff != count_ff);
         end
      end

      if (cmd.shift_run) begin
         if (issue_ff) begin
            arr_valid_in = 1'b1;
            arr_idx_in   = rd_ptr_ff;
            if (req_free_ff) begin
               issue_in  = (rd_ptr_ff != count_last);
               rd_ptr_in = rd_ptr_ff + CNT_ONE;
            end else begin
               issue_in  = (rd_ptr_ff != slot_ff);
               rd_ptr_in = rd_ptr_ff - CNT_ONE;
            end
         end
         if (arr_valid_ff) begin
            wr_en   = 1'b1;
            wr_data = rd_data;
            wr_addr = shift_dst[ADDR_W-1:0];
         end
      end

      if (cmd.commit) begin
         if (req_free_ff) begin
            count_in = count_ff - CNT_ONE;
         end else begin
            wr_en    = 1'b1;
            count_in = count_ff + CNT_ONE;
         end
      end

      if (cmd.push) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {INUSE_W'(count_ff), rsp_offset};
         rsp_user_in  = cmd.code;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= CNT_ZERO;
         issue_ff     <= 1'b0;
         arr_valid_ff <= 1'b0;
         done_ff      <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         issue_ff     <= issue_in;
         arr_valid_ff <= arr_valid_in;
         done_ff      <= done_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_free_ff <= req_free_in;
      size_ff     <= size_in;
      off_ff      <= off_in;
      rd_ptr_ff   <= rd_ptr_in;
      arr_idx_ff  <= arr_idx_in;
      prev_end_ff <= prev_end_in;
      base_ff     <= base_in;
      slot_ff     <= slot_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

[sv/first_fit_region_allocator.sv]
// Top level of the first-fit region allocator: controller plus datapath.
// One request at a time. Each request reads n table entries in the address-ordered scan and
// m entries in the shift, through the single-read-port region table at one entry per cycle;
// n + m is at most the live count plus two. The next request can be taken in the cycle
// after a response is posted.
// A synchronous active-high reset empties the table (count to zero) and drops any
// pending response; the table contents themselves are not cleared.
module first_fit_region_allocator import ffra_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   // Request channel.
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [15:0] alloc_size, [31:16] free_offset
   input  logic                  req_tuser,   // [0] req_type (0 allocate, 1 free)
   // Response channel.
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [15:0] region_offset, [23:16] regions_in_use
   output logic [1:0]            rsp_tuser    // [1:0] status
);

   ctrl_cmd_type cmd;
   dp_sts_type   sts;

   // Sequence each request: decide, scan, check, shift, commit, then hold the
   // response until the output register frees up.
   ffra_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // Region table, gap search, shift pointers and the response register. The
   // response register lets a result wait while the next request comes in.
   ffra_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .cmd        (cmd),
      .sts        (sts)
   );

endmodule

[sv/ffra_checker.sv]
// Port-level assertions for the first-fit region allocator, bound to the top level.
module ffra_checker import ffra_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic [1:0]            rsp_tuser
);

   // A stalled response holds its transfer.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   // One request in flight: no request taken right after a request.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while busy");

   // A full table reports the maximum region count.
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == STATUS_FULL) |->
         (rsp_tdata[RSP_DATA_W-1:FIELD_W] == INUSE_W'(MAX_REGION_ENTRIES)))
      else $error("table full with wrong region count");

   // Failed allocations return offset zero.
   a_fail_offset: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && ((rsp_tuser == STATUS_FULL) || (rsp_tuser == STATUS_NOMEM)) |->
         (rsp_tdata[FIELD_W-1:0] == '0))
      else $error("failed allocation with nonzero offset");

endmodule

bind first_fit_region_allocator ffra_checker u_ffra_checker (.*);

[dv/region_table_checker.sv]
// Checker for the region allocator: shadow region table, expected responses and comparison.
module region_table_checker import ffra_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [15:0] alloc_size, [31:16] free_offset
   input  logic                  req_tuser,   // [0] req_type
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,   // [15:0] region_offset, [23:16] regions_in_use
   input  logic [1:0]            rsp_tuser,   // [1:0] status
   output int                    mismatch_count,
   output int                    pending_results,
   output int                    ok_seen,
   output int                    full_seen,
   output int                    nomem_seen,
   output int                    notfound_seen,
   output int                    peak_live
);

   typedef struct packed {
      logic [FIELD_W-1:0] offset;
      status_type         status;
      logic [INUSE_W-1:0] in_use;
   } grant_type;

   logic [FIELD_W-1:0] start_shadow  [MAX_REGION_ENTRIES];
   logic [FIELD_W-1:0] length_shadow [MAX_REGION_ENTRIES];
   int                 live_shadow;
   grant_type          grants_due [$];

   initial begin
      mismatch_count  = 0;
      pending_results = 0;
      ok_seen         = 0;
      full_seen       = 0;
      nomem_seen      = 0;
      notfound_seen   = 0;
      peak_live       = 0;
      live_shadow     = 0;
   end

   function automatic int region_end_at(int idx);
      return int'(start_shadow[idx]) + int'(length_shadow[idx]);
   endfunction

   // First gap strictly wider than the request, else append after the last region.
   function automatic grant_type place_region(logic [FIELD_W-1:0] size);
      grant_type g;
      int        slot;
      int        base;
      int        gap;
      int        i;
      g.offset = '0;
      g.status = STATUS_OK;
      if (live_shadow >= MAX_REGION_ENTRIES) begin
         g.status = STATUS_FULL;
      end else begin
         slot = live_shadow;
         i = 1;
         while (i < live_shadow && slot == live_shadow) begin
            gap = int'(start_shadow[i]) - region_end_at(i - 1);
            if (gap < 0) gap = 0;
            if (gap > int'(size)) slot = i;
            i++;
         end
         base = (slot > 0) ? region_end_at(slot - 1) : 0;
         if (base + int'(size) >= MEMORY_WORDS) begin
            g.status = STATUS_NOMEM;
         end else begin
            for (i = live_shadow; i > slot; i--) begin
               start_shadow[i]  = start_shadow[i-1];
               length_shadow[i] = length_shadow[i-1];
            end
            start_shadow[slot]  = FIELD_W'(base);
            length_shadow[slot] = size;
            live_shadow++;
            g.offset = FIELD_W'(base);
         end
      end
      g.in_use = INUSE_W'(live_shadow);
      return g;
   endfunction

   // Drop the lowest-index live region starting at the offset.
   function automatic grant_type release_region(logic [FIELD_W-1:0] offset);
      grant_type g;
      int        hit;
      int        i;
      hit = live_shadow;
      for (i = live_shadow - 1; i >= 0; i--)
         if (start_shadow[i] == offset) hit = i;
      g.offset = offset;
      if (hit == live_shadow) begin
         g.status = STATUS_NOTFOUND;
      end else begin
         for (i = hit + 1; i < live_shadow; i++) begin
            start_shadow[i-1]  = start_shadow[i];
            length_shadow[i-1] = length_shadow[i];
         end
         live_shadow--;
         g.status = STATUS_OK;
      end
      g.in_use = INUSE_W'(live_shadow);
      return g;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      mismatch_count++;
      $display("MISMATCH at %0t: %s got %0d, want %0d", $time, what, got, want);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         live_shadow = 0;
         grants_due.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (grants_due.size() == 0) begin
               report_mismatch("response with nothing outstanding, offset",
                               int'(rsp_tdata[FIELD_W-1:0]), -1);
            end else begin
               grant_type want;
               want = grants_due.pop_front();
               if (rsp_tdata[FIELD_W-1:0] != want.offset)
                  report_mismatch("region_offset", int'(rsp_tdata[FIELD_W-1:0]),
                                  int'(want.offset));
               if (rsp_tuser != want.status)
                  report_mismatch("status", int'(rsp_tuser), int'(want.status));
               if (rsp_tdata[FIELD_W +: INUSE_W] != want.in_use)
                  report_mismatch("regions_in_use", int'(rsp_tdata[FIELD_W +: INUSE_W]),
                                  int'(want.in_use));
               case (want.status)
                  STATUS_OK:       ok_seen++;
                  STATUS_FULL:     full_seen++;
                  STATUS_NOMEM:    nomem_seen++;
                  STATUS_NOTFOUND: notfound_seen++;
                  default: ;
               endcase
            end
         end
         if (req_tvalid && req_tready) begin
            if (req_tuser == REQ_ALLOC)
               grants_due.push_back(place_region(req_tdata[FIELD_W-1:0]));
            else
               grants_due.push_back(release_region(req_tdata[FIELD_W +: FIELD_W]));
            if (live_shadow > peak_live) peak_live = live_shadow;
         end
      end
      pending_results = grants_due.size();
   end

endmodule

[dv/testbench.sv]
// Top of the region allocator testbench: clock, reset, request stimulus, response stalls, verdict.
module testbench;
   import ffra_pkg::*;

   // The limit covers 1700 worst-case requests plus the longest receiver stalls and
   // sender gaps, several times over.
   localparam int CYCLE_LIMIT  = 3_000_000;
   localparam int DRAIN_CYCLES = 300;
   localparam int HOLD_CYCLES  = 700;

   // Size profiles for random allocate requests.
   localparam int SIZES_SMALL = 0;
   localparam int SIZES_WIDE  = 1;
   localparam int SIZES_MIXED = 2;

   // Receiver stall patterns.
   localparam int RX_ALWAYS   = 0;
   localparam int RX_COIN     = 1;
   localparam int RX_SLOW     = 2;
   localparam int RX_PERIODIC = 3;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;   // [15:0] alloc_size, [31:16] free_offset
   logic                  req_tuser  = 1'b0; // [0] req_type
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;         // [15:0] region_offset, [23:16] regions_in_use
   logic [1:0]            rsp_tuser;         // [1:0] status

   int mismatch_count;
   int pending_results;
   int ok_seen, full_seen, nomem_seen, notfound_seen, peak_live;

   int                 sent_count  = 0;
   int                 cycle_count = 0;
   int                 burst_left  = 0;
   bit                 gaps_on     = 1'b1;
   logic               request_kinds [$];     // kinds of accepted requests, oldest first
   logic [FIELD_W-1:0] freeable_offsets [$];  // starts handed out by successful allocates

   first_fit_region_allocator i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   region_table_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .mismatch_count  (mismatch_count),
      .pending_results (pending_results),
      .ok_seen         (ok_seen),
      .full_seen       (full_seen),
      .nomem_seen      (nomem_seen),
      .notfound_seen   (notfound_seen),
      .peak_live       (peak_live)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Watchdog: give up once the cycle budget is spent.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("** first_fit_region_allocator: FAILED **");
      $finish;
   end

   // Collect the starts of granted regions so that most frees name a live region.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         if (request_kinds.pop_front() == REQ_ALLOC && rsp_tuser == STATUS_OK)
            freeable_offsets.push_back(rsp_tdata[FIELD_W-1:0]);
   end

   // Present one request and hold it until the transfer. Bursts of random length
   // are usually separated by random gaps while gaps_on is set.
   task automatic send_request(logic kind, logic [FIELD_W-1:0] size,
                               logic [FIELD_W-1:0] offset);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         if (gaps_on && $urandom_range(3) != 0) begin
            gap = $urandom_range(1, 8);
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {offset, size};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      request_kinds.push_back(kind);
      sent_count++;
   endtask

   // Lower valid and wait until every expected response has come back.
   task automatic pause_until_drained();
      req_tvalid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
   endtask

   // One random request. Frees mostly name a granted start; the rest are noise.
   task automatic random_request(int alloc_pct, int size_mode);
      logic [FIELD_W-1:0] size;
      logic [FIELD_W-1:0] offset;
      int                 profile;
      int                 pick;
      size   = FIELD_W'($urandom);
      offset = FIELD_W'($urandom);
      if ($urandom_range(99) < alloc_pct) begin
         profile = (size_mode == SIZES_MIXED) ? $urandom_range(1) : size_mode;
         if (profile == SIZES_SMALL) begin
            case ($urandom_range(7))
               0:       size = '0;
               1:       size = FIELD_W'($urandom_range(0, 2000));
               default: size = FIELD_W'($urandom_range(0, 255));
            endcase
         end else begin
            case ($urandom_range(3))
               0:       size = FIELD_W'($urandom_range(0, 255));
               1:       size = FIELD_W'($urandom_range(32768, 65535));
               default: ; // keep the full-range draw
            endcase
         end
         send_request(REQ_ALLOC, size, offset);
      end else begin
         if (freeable_offsets.size() > 0 && $urandom_range(99) < 85) begin
            pick   = $urandom_range(freeable_offsets.size() - 1);
            offset = freeable_offsets[pick];
            freeable_offsets.delete(pick);
         end else if ($urandom_range(3) == 0) begin
            offset = '0;
         end
         send_request(REQ_FREE, size, offset);
      end
   endtask

   // Receiver: change stall pattern at random intervals; twice, hold off for a
   // long stretch while the sender keeps offering, so the block backs up.
   initial begin
      int mode;
      int span;
      int step;
      int holds_done;
      holds_done = 0;
      while (reset) @(posedge clock);
      forever begin
         if (holds_done < 2 && sent_count >= ((holds_done == 0) ? 250 : 1100)) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            holds_done++;
         end else begin
            mode = $urandom_range(3);
            span = $urandom_range(50, 400);
            for (step = 0; step < span; step++) begin
               case (mode)
                  RX_ALWAYS:   rsp_tready <= 1'b1;
                  RX_COIN:     rsp_tready <= 1'($urandom_range(1));
                  RX_SLOW:     rsp_tready <= ($urandom_range(4) == 0);
                  RX_PERIODIC: rsp_tready <= (step % 5 == 0);
                  default:     rsp_tready <= 1'b1;
               endcase
               @(posedge clock);
            end
         end
      end
   end

   // Stimulus and verdict.
   initial begin
      int n;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty table, zero sizes, duplicate starts, gap fitting, memory edge.
      send_request(REQ_FREE,  16'd0,     16'd0);     // free on an empty table: not found
      send_request(REQ_ALLOC, 16'd0,     16'hFFFF);  // zero size on empty table: offset 0
      send_request(REQ_ALLOC, 16'd0,     16'hFFFF);  // second region starting at 0
      send_request(REQ_FREE,  16'hFFFF,  16'd0);     // duplicate start: lowest index goes
      send_request(REQ_FREE,  16'hFFFF,  16'd0);     // and then the other one
      send_request(REQ_ALLOC, 16'd100,   16'd0);     // 0
      send_request(REQ_ALLOC, 16'd50,    16'd0);     // 100
      send_request(REQ_ALLOC, 16'd200,   16'd0);     // 150
      send_request(REQ_FREE,  16'd0,     16'd100);   // opens a 50-word gap at 100
      send_request(REQ_ALLOC, 16'd50,    16'd0);     // gap not strictly larger: append
      send_request(REQ_ALLOC, 16'd49,    16'd0);     // fits the gap at 100
      send_request(REQ_ALLOC, 16'd0,     16'd0);     // zero size takes the last free word
      send_request(REQ_FREE,  16'd0,     16'hFFFF);  // unknown start
      send_request(REQ_ALLOC, 16'hFFFF,  16'hFFFF);  // past the end of memory
      send_request(REQ_FREE,  16'd0,     16'd0);
      send_request(REQ_FREE,  16'd0,     16'd100);
      send_request(REQ_FREE,  16'd0,     16'd149);
      send_request(REQ_FREE,  16'd0,     16'd150);
      send_request(REQ_FREE,  16'd0,     16'd350);
      send_request(REQ_ALLOC, 16'hFFFF,  16'd0);     // whole memory but the last word
      send_request(REQ_ALLOC, 16'd0,     16'd0);     // zero size at the top word
      send_request(REQ_ALLOC, 16'd1,     16'd0);     // one word more: out of memory
      send_request(REQ_FREE,  16'd0,     16'hFFFF);
      send_request(REQ_FREE,  16'd0,     16'd0);
      pause_until_drained();

      // Churn with small regions.
      for (n = 0; n < 500; n++) random_request(60, SIZES_SMALL);
      pause_until_drained();

      // Fill the table past its capacity, back to back.
      gaps_on = 1'b0;
      for (n = 0; n < 300; n++) random_request(90, SIZES_SMALL);
      gaps_on = 1'b1;
      pause_until_drained();

      // Drain it again, mostly by freeing granted regions.
      for (n = 0; n < 250; n++) random_request(15, SIZES_SMALL);
      pause_until_drained();

      // Wide sizes: memory runs out often.
      for (n = 0; n < 350; n++) random_request(60, SIZES_WIDE);
      pause_until_drained();

      // Everything mixed.
      for (n = 0; n < 276; n++) random_request(55, SIZES_MIXED);
      pause_until_drained();

      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d requests: %0d ok, %0d table full, %0d out of memory, %0d not found.",
               sent_count, ok_seen, full_seen, nomem_seen, notfound_seen);
      $display("Peak live regions %0d, %0d cycles, %0d mismatches.",
               peak_live, cycle_count, mismatch_count);
      if (mismatch_count == 0 && pending_results == 0)
         $display("** first_fit_region_allocator: PASSED **");
      else
         $display("** first_fit_region_allocator: FAILED **");
      $finish;
   end

endmodule

[first_fit_region_allocator.f]
sv/ffra_pkg.sv
sv/ffra_ram.sv
sv/ffra_ctrl.sv
sv/ffra_dp.sv
sv/first_fit_region_allocator.sv
sv/ffra_checker.sv
dv/region_table_checker.sv
dv/testbench.sv
